// File: rtl/csvg_pkg.sv
// Shared types and register codes of the cube sphere vertex generator.
`timescale 1ns / 1ps

package csvg_pkg;

   // Widths fixed by the item fields
   localparam int GRID_W  = 8;
   localparam int RES_W   = 9;
   localparam int UP_W    = 2;
   localparam int INDEX_W = 19;
   localparam int VERT_W  = 16;
   localparam int CSR_IDX_W = 3;

   // Largest scaled cube coordinate fits in this many signed bits.
   localparam int QW = 14;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_RESOLUTION = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UP_X            = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UP_Y            = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UP_Z            = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_OFFSET    = 3'd4;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;
   typedef logic [INDEX_W-1:0]   csr_data_type;

   typedef struct packed {
      logic [GRID_W-1:0] grid_x;
      logic [GRID_W-1:0] grid_y;
   } req_type;

   typedef struct packed {
      logic                 has_cell;
      logic [INDEX_W-1:0]   tri_a0;
      logic [INDEX_W-1:0]   tri_a1;
      logic [INDEX_W-1:0]   tri_a2;
      logic [INDEX_W-1:0]   tri_b0;
      logic [INDEX_W-1:0]   tri_b1;
      logic [INDEX_W-1:0]   tri_b2;
   } cell_type;

   typedef struct packed {
      logic signed [VERT_W-1:0] vert_x;
      logic signed [VERT_W-1:0] vert_y;
      logic signed [VERT_W-1:0] vert_z;
      logic                     has_cell;
      logic [INDEX_W-1:0]       tri_a0;
      logic [INDEX_W-1:0]       tri_a1;
      logic [INDEX_W-1:0]       tri_a2;
      logic [INDEX_W-1:0]       tri_b0;
      logic [INDEX_W-1:0]       tri_b1;
      logic [INDEX_W-1:0]       tri_b2;
   } rsp_type;

endpackage

// File: rtl/cube_sphere_vertex_gen.sv
// Cube sphere vertex generator: grid point in, unit sphere vertex and cell indices out.
`timescale 1ns / 1ps

// One grid point (x, y) of a cube face goes in per item and one vertex comes out per item.
// The pipeline takes one item per cycle when nothing stalls and holds COORD_FRAC_BITS + 5
// stages; the depth is set by the normalisation, which settles one result bit per stage.
// A stalled output holds its item while the stages in front fill their empty slots.
// Configuration is written through the csr channel, which is always ready, and may only
// change while no item is in flight.
module cube_sphere_vertex_gen #(
   parameter int MAX_RESOLUTION  = 256,
   parameter int COORD_FRAC_BITS = 14
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  csvg_pkg::req_type      req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output csvg_pkg::rsp_type      rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  csvg_pkg::csr_index_type csr_index,
   input  csvg_pkg::csr_data_type  csr_data
);
   import csvg_pkg::*;

   localparam int F    = COORD_FRAC_BITS;
   localparam int NB   = F + 1;
   localparam int SW   = 2 * QW + 2;
   localparam int W    = 2 * F + 4 + SW;
   localparam int NST  = NB + 4;
   localparam int LAST = NST - 1;
   localparam int IW   = INDEX_W + 1;
   localparam int RMAX = (MAX_RESOLUTION > 511) ? 511 : MAX_RESOLUTION;
   localparam longint LIM6 = 64'(6) * longint'(MAX_RESOLUTION) * longint'(MAX_RESOLUTION) - 1;
   localparam longint LIMC = (LIM6 > 524287) ? 524287 : LIM6;
   localparam logic [IW-1:0]    IDX_LIM = IW'(LIMC);
   localparam logic [RES_W-1:0] RES_MAX = RES_W'(RMAX);

   typedef struct packed {
      logic [2:0][NB-1:0] n;
      logic [2:0][W-1:0]  a;
      logic [2:0][W-1:0]  b;
      logic [2:0][W-1:0]  rr;
      logic [2:0]         neg;
      logic [SW-1:0]      s;
      cell_type           mesh;
   } norm_type;

   // Configuration registers
   logic [RES_W-1:0]       res_ff;
   logic signed [UP_W-1:0] ux_ff, uy_ff, uz_ff;
   logic [INDEX_W-1:0]     off_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff <= 9'd2;
         ux_ff  <= 2'sd0;
         uy_ff  <= 2'sd1;
         uz_ff  <= 2'sd0;
         off_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_GRID_RESOLUTION: res_ff <= csr_data[RES_W-1:0];
            CSR_UP_X:            ux_ff  <= csr_data[UP_W-1:0];
            CSR_UP_Y:            uy_ff  <= csr_data[UP_W-1:0];
            CSR_UP_Z:            uz_ff  <= csr_data[UP_W-1:0];
            CSR_INDEX_OFFSET:    off_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Clamped resolution, shared by several stages
   logic [RES_W-1:0] rc;
   always_comb begin
      if (res_ff < 9'd2) rc = 9'd2;
      else if (res_ff > RES_MAX) rc = RES_MAX;
      else rc = res_ff;
   end

   // Stage advance: a stage moves when it is empty or the one after it moves.
   logic [NST-1:0] valid_ff;
   logic [NST-1:0] adv;

   always_comb begin
      adv[LAST] = !valid_ff[LAST] || !rsp_stall;
      for (int k = LAST - 1; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k + 1];
      end
   end

   assign req_stall = !adv[0];
   assign rsp_valid = valid_ff[LAST];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) valid_ff[0] <= req_valid;
         for (int k = 1; k < NST; k++) begin
            if (adv[k]) valid_ff[k] <= valid_ff[k - 1];
         end
      end
   end

   // Input register
   logic [GRID_W-1:0] x1_ff, y1_ff;
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         x1_ff <= req_data.grid_x;
         y1_ff <= req_data.grid_y;
      end
   end

   // Cube point from the up axis and its two tangent axes, and the cell base index
   logic signed [15:0] ux, uy, uz, d16, s16, t16, bx, by, bz, qx, qy, qz;
   logic [IW-1:0]      base_in;
   logic               has_in;

   always_comb begin
      ux  = 16'(ux_ff);
      uy  = 16'(uy_ff);
      uz  = 16'(uz_ff);
      d16 = $signed({7'd0, rc}) - 16'sd1;
      s16 = $signed({7'd0, x1_ff, 1'b0}) - d16;
      t16 = $signed({7'd0, y1_ff, 1'b0}) - d16;
      bx  = uy * ux - uz * uz;
      by  = uz * uy - ux * ux;
      bz  = ux * uz - uy * uy;
      qx  = ux * d16 + s16 * uy + t16 * bx;
      qy  = uy * d16 + s16 * uz + t16 * by;
      qz  = uz * d16 + s16 * ux + t16 * bz;
      base_in = IW'(x1_ff) + IW'(y1_ff) * IW'(rc) + IW'(off_ff);
      has_in  = (RES_W'(x1_ff) < rc - 9'd1) && (RES_W'(y1_ff) < rc - 9'd1);
   end

   logic signed [2:0][QW-1:0] q2_ff;
   logic [IW-1:0]             base2_ff;
   logic                      has2_ff;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         q2_ff[0] <= qx[QW-1:0];
         q2_ff[1] <= qy[QW-1:0];
         q2_ff[2] <= qz[QW-1:0];
         base2_ff <= base_in;
         has2_ff  <= has_in;
      end
   end

   function automatic logic [INDEX_W-1:0] sat_index(input logic [IW-1:0] v);
      logic [IW-1:0] r;
      r = (v > IDX_LIM) ? IDX_LIM : v;
      return r[INDEX_W-1:0];
   endfunction

   // Squared length, squared magnitudes and saturated triangle indices
   norm_type norm_ff [NB+1];
   norm_type norm_in [NB+1];

   always_comb begin
      logic [QW-1:0]   ac;
      logic [2*QW-1:0] c2;
      logic [SW-1:0]   sum;
      logic [IW-1:0]   r1;
      norm_in[0] = '0;
      sum = '0;
      for (int k = 0; k < 3; k++) begin
         ac = q2_ff[k][QW-1] ? QW'(-q2_ff[k]) : QW'(q2_ff[k]);
         c2 = (2*QW)'(ac) * (2*QW)'(ac);
         sum = sum + SW'(c2);
         norm_in[0].rr[k]  = W'(c2) << (2 * F + 2);
         norm_in[0].neg[k] = q2_ff[k][QW-1];
      end
      norm_in[0].s = sum;
      r1 = IW'(rc);
      if (has2_ff) begin
         norm_in[0].mesh.has_cell = 1'b1;
         norm_in[0].mesh.tri_a0 = sat_index(base2_ff);
         norm_in[0].mesh.tri_a1 = sat_index(base2_ff + r1 + 20'd1);
         norm_in[0].mesh.tri_a2 = sat_index(base2_ff + r1);
         norm_in[0].mesh.tri_b0 = sat_index(base2_ff);
         norm_in[0].mesh.tri_b1 = sat_index(base2_ff + 20'd1);
         norm_in[0].mesh.tri_b2 = sat_index(base2_ff + r1 + 20'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[2]) norm_ff[0] <= norm_in[0];
   end

   // Normalisation: one result bit per stage, tracking n*s and n*n*s by shifts and adds
   for (genvar j = 0; j < NB; j++) begin : g_norm
      localparam int BIT = F - j;

      always_comb begin
         logic [W-1:0] sw, ks, ka, lhs;
         norm_in[j + 1] = norm_ff[j];
         sw = W'(norm_ff[j].s);
         ks = (sw << (2 * BIT + 2)) - (sw << (BIT + 2)) + sw;
         for (int k = 0; k < 3; k++) begin
            ka  = (norm_ff[j].a[k] << (BIT + 1)) - norm_ff[j].a[k];
            lhs = (norm_ff[j].b[k] << 2) + (ka << 2) + ks;
            if (lhs <= norm_ff[j].rr[k]) begin
               norm_in[j + 1].n[k][BIT] = 1'b1;
               norm_in[j + 1].a[k] = norm_ff[j].a[k] + (sw << BIT);
               norm_in[j + 1].b[k] = norm_ff[j].b[k] + (norm_ff[j].a[k] << (BIT + 1))
                                     + (sw << (2 * BIT));
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv[3 + j]) norm_ff[j + 1] <= norm_in[j + 1];
      end
   end

   // Output register: zero length, saturation and sign
   rsp_type out_in, out_ff;

   always_comb begin
      logic [NB-1:0]      nn;
      logic [VERT_W-2:0]  mag;
      logic [2:0][VERT_W-1:0] v;
      for (int k = 0; k < 3; k++) begin
         nn  = (norm_ff[NB].s == '0) ? '0 : norm_ff[NB].n[k];
         mag = (nn > 32767) ? 15'h7fff : 15'(nn);
         v[k] = norm_ff[NB].neg[k] ? -{1'b0, mag} : {1'b0, mag};
      end
      out_in.vert_x   = v[0];
      out_in.vert_y   = v[1];
      out_in.vert_z   = v[2];
      out_in.has_cell = norm_ff[NB].mesh.has_cell;
      out_in.tri_a0   = norm_ff[NB].mesh.tri_a0;
      out_in.tri_a1   = norm_ff[NB].mesh.tri_a1;
      out_in.tri_a2   = norm_ff[NB].mesh.tri_a2;
      out_in.tri_b0   = norm_ff[NB].mesh.tri_b0;
      out_in.tri_b1   = norm_ff[NB].mesh.tri_b1;
      out_in.tri_b2   = norm_ff[NB].mesh.tri_b2;
   end

   always_ff @(posedge clock) begin
      if (adv[LAST]) out_ff <= out_in;
   end

   assign rsp_data = out_ff;

endmodule

// File: tb/cube_sphere_vertex_gen_checker.sv
// Result checker for the cube sphere vertex generator: predicts each vertex and compares.
`timescale 1ns / 1ps

module cube_sphere_vertex_gen_checker (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  csvg_pkg::req_type       req_data,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  csvg_pkg::rsp_type       rsp_data,
   input  logic                    csr_valid,
   input  logic                    csr_ready,
   input  csvg_pkg::csr_index_type csr_index,
   input  csvg_pkg::csr_data_type  csr_data,
   output int                      failures,
   output int                      pending
);
   import csvg_pkg::*;

   localparam int FRAC_BITS = 14;
   localparam int MAX_RES   = 256;
   localparam longint INDEX_LIMIT = 6 * MAX_RES * MAX_RES - 1;

   // Shadow copy of the face configuration.
   logic [RES_W-1:0]        res_reg;
   logic signed [UP_W-1:0]  upx_reg, upy_reg, upz_reg;
   logic [INDEX_W-1:0]      offset_reg;

   rsp_type vertex_queue[$];

   // Exact round(c * 2^F / sqrt(s2)), settled one bit at a time from the top.
   function automatic longint unit_coord(longint c, longint unsigned s2);
      longint unsigned ac, n, tt, m;
      bit [127:0] rhs, lhs;
      ac = (c < 0) ? -c : c;
      rhs = {64'b0, ac * ac} << (2 * FRAC_BITS + 2);
      n = 0;
      for (int b = FRAC_BITS; b >= 0; b--) begin
         tt = n | (64'd1 << b);
         m = 2 * tt - 1;
         lhs = {64'b0, m * m} * {64'b0, s2};
         if (lhs <= rhs) n = tt;
      end
      if (n > 32767) n = 32767;
      return (c < 0) ? -longint'(n) : longint'(n);
   endfunction

   function automatic logic [INDEX_W-1:0] clip_index(longint v);
      return (v > INDEX_LIMIT) ? INDEX_W'(INDEX_LIMIT) : INDEX_W'(v);
   endfunction

   function automatic rsp_type predict_vertex(req_type p);
      rsp_type o;
      longint r, d, x, y, s, t, ux, uy, uz, ax, ay, az, bx, by, bz, i;
      longint q[3];
      longint unsigned s2;
      longint v[3];
      r = res_reg;
      if (r < 2) r = 2;
      if (r > MAX_RES) r = MAX_RES;
      d = r - 1;
      x = p.grid_x;
      y = p.grid_y;
      s = 2 * x - d;
      t = 2 * y - d;
      ux = upx_reg; uy = upy_reg; uz = upz_reg;
      // Tangents: rotated components, then the cross product with the up axis.
      ax = uy; ay = uz; az = ux;
      bx = uy * az - uz * ay;
      by = uz * ax - ux * az;
      bz = ux * ay - uy * ax;
      q[0] = ux * d + s * ax + t * bx;
      q[1] = uy * d + s * ay + t * by;
      q[2] = uz * d + s * az + t * bz;
      s2 = q[0] * q[0] + q[1] * q[1] + q[2] * q[2];
      for (int k = 0; k < 3; k++) v[k] = (s2 == 0) ? 0 : unit_coord(q[k], s2);
      o = '0;
      o.vert_x = VERT_W'(v[0]);
      o.vert_y = VERT_W'(v[1]);
      o.vert_z = VERT_W'(v[2]);
      // Cell indices only for points with a neighbour to the right and below.
      if (x < d && y < d) begin
         i = x + y * r + longint'(offset_reg);
         o.has_cell = 1'b1;
         o.tri_a0 = clip_index(i);
         o.tri_a1 = clip_index(i + r + 1);
         o.tri_a2 = clip_index(i + r);
         o.tri_b0 = clip_index(i);
         o.tri_b1 = clip_index(i + 1);
         o.tri_b2 = clip_index(i + r + 1);
      end
      return o;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("MISMATCH %s: got %0d, expected %0d", field, got, want);
      failures++;
   endtask

   initial begin
      failures = 0;
      pending = 0;
   end

   // Track configuration, record expectations and compare accepted items.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         res_reg    <= 9'd2;
         upx_reg    <= 2'sd0;
         upy_reg    <= 2'sd1;
         upz_reg    <= 2'sd0;
         offset_reg <= '0;
         vertex_queue.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_GRID_RESOLUTION: res_reg    <= csr_data[RES_W-1:0];
               CSR_UP_X:            upx_reg    <= csr_data[UP_W-1:0];
               CSR_UP_Y:            upy_reg    <= csr_data[UP_W-1:0];
               CSR_UP_Z:            upz_reg    <= csr_data[UP_W-1:0];
               CSR_INDEX_OFFSET:    offset_reg <= csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) vertex_queue = {vertex_queue, predict_vertex(req_data)};
         if (rsp_valid && !rsp_stall) begin
            if (vertex_queue.size() == 0) begin
               report_mismatch("unexpected item", 1, 0);
            end else begin
               want = vertex_queue.pop_front();
               if (rsp_data.vert_x !== want.vert_x)
                  report_mismatch("vert_x", rsp_data.vert_x, want.vert_x);
               if (rsp_data.vert_y !== want.vert_y)
                  report_mismatch("vert_y", rsp_data.vert_y, want.vert_y);
               if (rsp_data.vert_z !== want.vert_z)
                  report_mismatch("vert_z", rsp_data.vert_z, want.vert_z);
               if (rsp_data.has_cell !== want.has_cell)
                  report_mismatch("has_cell", rsp_data.has_cell, want.has_cell);
               if (rsp_data.tri_a0 !== want.tri_a0)
                  report_mismatch("tri_a0", rsp_data.tri_a0, want.tri_a0);
               if (rsp_data.tri_a1 !== want.tri_a1)
                  report_mismatch("tri_a1", rsp_data.tri_a1, want.tri_a1);
               if (rsp_data.tri_a2 !== want.tri_a2)
                  report_mismatch("tri_a2", rsp_data.tri_a2, want.tri_a2);
               if (rsp_data.tri_b0 !== want.tri_b0)
                  report_mismatch("tri_b0", rsp_data.tri_b0, want.tri_b0);
               if (rsp_data.tri_b1 !== want.tri_b1)
                  report_mismatch("tri_b1", rsp_data.tri_b1, want.tri_b1);
               if (rsp_data.tri_b2 !== want.tri_b2)
                  report_mismatch("tri_b2", rsp_data.tri_b2, want.tri_b2);
            end
         end
      end
      pending = vertex_queue.size();
   end

endmodule

// File: tb/cube_sphere_vertex_gen_test.sv
// Top-level testbench of the cube sphere vertex generator: stimulus and verdict.
`timescale 1ns / 1ps

module cube_sphere_vertex_gen_test;
   import csvg_pkg::*;

   localparam int LATENCY     = 19;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 200;

   typedef struct {
      int res;
      int ux, uy, uz;
      int off;
   } face_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   req_type       req_data = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   rsp_type       rsp_data;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = CSR_GRID_RESOLUTION;
   csr_data_type  csr_data = '0;
   int            failures, pending;
   int            cycles = 0;
   bit            long_hold = 1'b0;
   bit            quiet = 1'b0;
   int            res_now = 2;

   face_type faces[9] = '{
      '{256, 0, 1, 0, 327680},
      '{2, 1, 0, 0, 0},
      '{17, -1, 0, 0, 1000},
      '{0, 0, 0, -1, 524287},
      '{511, 0, -1, 0, 65536},
      '{100, -2, 1, 1, 200000},
      '{5, 0, 0, 0, 0},
      '{64, 0, 0, 1, 393215},
      '{33, -2, -2, -2, 12345}
   };

   cube_sphere_vertex_gen dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   cube_sphere_vertex_gen_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .failures(failures), .pending(pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Holds the write valid high; the caller drops it after the last write.
   task automatic write_csr(csr_index_type idx, int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= INDEX_W'(value);
      do @(posedge clock); while (!csr_ready);
   endtask

   // Offer one item after a random gap and hold it until it is taken.
   task automatic send_point(int x, int y);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= {GRID_W'(x), GRID_W'(y)};
      do @(posedge clock); while (req_stall);
   endtask

   // Let every expected item arrive and the pipeline empty out.
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic apply_face(face_type f);
      write_csr(CSR_GRID_RESOLUTION, f.res);
      write_csr(CSR_UP_X, f.ux & 3);
      write_csr(CSR_UP_Y, f.uy & 3);
      write_csr(CSR_UP_Z, f.uz & 3);
      write_csr(CSR_INDEX_OFFSET, f.off);
      csr_valid <= 1'b0;
      res_now = (f.res < 2) ? 2 : (f.res > 256) ? 256 : f.res;
   endtask

   // Receiver: random stalls per item, with one long hold-off on request.
   initial begin
      int n;
      @(negedge reset);
      forever begin
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (80) @(posedge clock);
            long_hold = 1'b0;
         end
         n = quiet ? 0 : $urandom_range(0, 4);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Stimulus and verdict.
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset face: points on and beyond a two-point grid, and field extremes.
      send_point(0, 0);
      send_point(1, 0);
      send_point(255, 255);
      send_point(0, 255);
      drain();

      for (int p = 0; p < 9; p++) begin
         apply_face(faces[p]);
         quiet = (p == 4);
         if (p == 0) begin
            // Corners, the last cell, saturating neighbours and edge points without a cell.
            send_point(0, 0);
            send_point(255, 255);
            send_point(254, 254);
            send_point(255, 0);
            send_point(0, 255);
            send_point(254, 0);
            send_point(0, 254);
            send_point(128, 127);
            send_point(170, 85);
            send_point(85, 170);
         end
         if (p == 2) long_hold = 1'b1;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if ($urandom_range(0, 9) < 8)
               send_point($urandom_range(0, res_now - 1), $urandom_range(0, res_now - 1));
            else
               send_point($urandom_range(0, 255), $urandom_range(0, 255));
            if (p == 5 && k == PHASE_ITEMS / 2) drain();
         end
         drain();
      end

      repeat (LATENCY + 10) @(posedge clock);
      if (failures == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// File: cube_sphere_vertex_gen.f
rtl/csvg_pkg.sv
rtl/cube_sphere_vertex_gen.sv
tb/cube_sphere_vertex_gen_checker.sv
tb/cube_sphere_vertex_gen_test.sv
